/* hdl/pgalloc_pkg.sv */
// Package for the page allocator: payload types, codes and field widths.
`default_nettype none

package pgalloc_pkg;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int OWNER_W    = 8;
  localparam int POLICY_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

  // Fit policies (any other code behaves as first fit)
  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PAGES = 4'd1;

  // Request item
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COUNT_W-1:0]  request_size;
    logic [OWNER_W-1:0]  owner_job;
  } req_t;

  // Response item
  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] free_pages;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/page_allocator_fit_policies.sv */
// Page allocator with first, best and worst fit over a page table memory.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  req     | in  | req_valid/req_stall | action, request_size, owner_job
//  rsp     | out | rsp_valid/rsp_stall | success, free_pages
//  cfg     | in  | cfg_wr_en           | cfg_index, cfg_data
//
// Clear writes the whole table, one table write per cycle.
// Allocate, free and unknown actions scan the n active pages and an end
// marker through the table's single read port, then, when an allocation
// succeeds, write request_size pages.
// After reset a clearing pass over the whole table runs before the first item.
// One item at a time; the next is taken while a response waits in rsp.
`default_nettype none

module page_allocator_fit_policies #(
  parameter int MAX_PAGES = 64,
  parameter int JOB_BITS  = 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  req_valid,
  output logic                                 req_stall,
  input  pgalloc_pkg::req_t                    req,
  output logic                                 rsp_valid,
  input  wire                                  rsp_stall,
  output pgalloc_pkg::rsp_t                    rsp,
  input  wire                                  cfg_wr_en,
  input  wire  [pgalloc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pgalloc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = pgalloc_pkg::COUNT_W;
  // Highest usable active count: the register is 7 bits wide
  localparam int NMAX = (MAX_PAGES > 127) ? 127 : MAX_PAGES;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  // Configuration
  logic [pgalloc_pkg::POLICY_W-1:0] fit_policy;
  logic [CW-1:0]                    active_pages;

  // Sequencer
  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          clr_reply, clr_reply_next;
  logic [pgalloc_pkg::ACTION_W-1:0] act, act_next;
  logic [CW-1:0] size, size_next;
  logic [JOB_BITS-1:0] job, job_next;
  logic [CW-1:0] n_reg, n_reg_next;
  logic          nofit, nofit_next;
  logic [CW-1:0] ptr, ptr_next;
  logic          issue_done, issue_done_next;
  logic          q_vld, q_vld_next;
  logic [CW-1:0] q_idx, q_idx_next;
  logic [CW-1:0] run_len, run_len_next;
  logic [CW-1:0] run_start, run_start_next;
  logic          have, have_next;
  logic [CW-1:0] pick_start, pick_start_next;
  logic [CW-1:0] pick_len, pick_len_next;
  logic [CW-1:0] cnt_free, cnt_free_next;
  logic [CW-1:0] wptr, wptr_next;
  logic [CW-1:0] wend, wend_next;
  logic          res_ok, res_ok_next;
  logic [CW-1:0] res_free, res_free_next;
  logic          rsp_valid_next;
  pgalloc_pkg::rsp_t rsp_next;

  // Page table: {taken, owner}
  logic [JOB_BITS:0] page_mem [MAX_PAGES];
  logic [JOB_BITS:0] mem_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [JOB_BITS:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  // Scan datapath signals
  logic          live, taken, match, free_here, first_fit, better, scan_last;
  logic [CW-1:0] start_eff, len_inc, n_now;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_wa] <= mem_wd;
    end
    mem_q <= page_mem[mem_ra];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy   <= pgalloc_pkg::FIT_FIRST;
      active_pages <= 7'd64;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pgalloc_pkg::REG_FIT_POLICY:   fit_policy   <= cfg_data[pgalloc_pkg::POLICY_W-1:0];
        pgalloc_pkg::REG_ACTIVE_PAGES: active_pages <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active count saturated at the table size
  assign n_now = (active_pages > CW'(NMAX)) ? CW'(NMAX) : active_pages;

  // Per-page scan terms for the entry now on the read port
  assign live      = (q_idx != n_reg);
  assign taken     = mem_q[JOB_BITS];
  assign match     = (act == pgalloc_pkg::ACT_FREE) && live && taken &&
                     (mem_q[JOB_BITS-1:0] == job);
  assign free_here = live && !taken;
  assign first_fit = (fit_policy != pgalloc_pkg::FIT_BEST) &&
                     (fit_policy != pgalloc_pkg::FIT_WORST);
  assign start_eff = (run_len == '0) ? q_idx : run_start;
  assign len_inc   = run_len + CW'(1);
  assign better    = !nofit && (run_len >= size) &&
                     (!have || ((fit_policy == pgalloc_pkg::FIT_BEST) ?
                                (run_len < pick_len) : (run_len > pick_len)));
  assign scan_last = q_vld && (q_idx == n_reg);

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    clr_reply_next  = clr_reply;
    act_next        = act;
    size_next       = size;
    job_next        = job;
    n_reg_next      = n_reg;
    nofit_next      = nofit;
    ptr_next        = ptr;
    issue_done_next = issue_done;
    q_vld_next      = 1'b0;
    q_idx_next      = q_idx;
    run_len_next    = run_len;
    run_start_next  = run_start;
    have_next       = have;
    pick_start_next = pick_start;
    pick_len_next   = pick_len;
    cnt_free_next   = cnt_free;
    wptr_next       = wptr;
    wend_next       = wend;
    res_ok_next     = res_ok;
    res_free_next   = res_free;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    mem_we          = 1'b0;
    mem_wa          = clr_addr;
    mem_wd          = '0;
    mem_ra          = AW'(ptr);

    case (state)
      // Clearing pass over the whole table
      S_CLR: begin
        mem_we        = 1'b1;
        mem_wa        = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_PAGES - 1)) begin
          res_ok_next   = 1'b1;
          res_free_next = n_reg;
          state_next    = clr_reply ? S_FIN : S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          act_next        = req.action;
          size_next       = req.request_size;
          job_next        = JOB_BITS'(req.owner_job);
          n_reg_next      = n_now;
          nofit_next      = (req.request_size == '0) || (req.request_size > n_now);
          ptr_next        = '0;
          issue_done_next = 1'b0;
          run_len_next    = '0;
          run_start_next  = '0;
          have_next       = 1'b0;
          pick_start_next = '0;
          pick_len_next   = '0;
          cnt_free_next   = '0;
          clr_addr_next   = '0;
          clr_reply_next  = 1'b1;
          state_next      = (req.action == pgalloc_pkg::ACT_CLEAR) ? S_CLR : S_SCAN;
        end
      end

      // Read pages 0..n (n is the end marker), processed in the cycle after the read
      S_SCAN: begin
        if (!issue_done) begin
          q_vld_next = 1'b1;
          q_idx_next = ptr;
          if (ptr == n_reg) begin
            issue_done_next = 1'b1;
          end else begin
            ptr_next = ptr + CW'(1);
          end
        end
        if (q_vld) begin
          if (free_here || match) begin
            cnt_free_next = cnt_free + CW'(1);
          end
          // free: release pages of the job
          if (match) begin
            mem_we = 1'b1;
            mem_wa = AW'(q_idx);
            mem_wd = '0;
          end
          // allocate: track holes
          if (act == pgalloc_pkg::ACT_ALLOC) begin
            if (free_here) begin
              run_start_next = start_eff;
              run_len_next   = len_inc;
              if (first_fit && !have && !nofit && (len_inc >= size)) begin
                have_next       = 1'b1;
                pick_start_next = start_eff;
              end
            end else begin
              if (!first_fit && (run_len != '0) && better) begin
                have_next       = 1'b1;
                pick_start_next = run_start;
                pick_len_next   = run_len;
              end
              run_len_next = '0;
            end
          end
        end
        if (scan_last) begin
          case (act)
            pgalloc_pkg::ACT_ALLOC: begin
              res_ok_next   = have_next;
              res_free_next = have_next ? (cnt_free_next - size) : cnt_free_next;
            end
            pgalloc_pkg::ACT_FREE: begin
              res_ok_next   = 1'b1;
              res_free_next = cnt_free_next;
            end
            default: begin
              res_ok_next   = 1'b0;
              res_free_next = cnt_free_next;
            end
          endcase
          wptr_next  = pick_start_next;
          wend_next  = pick_start_next + size - CW'(1);
          state_next = ((act == pgalloc_pkg::ACT_ALLOC) && have_next) ? S_WRITE : S_FIN;
        end
      end

      // Mark the chosen run, one page a cycle
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(wptr);
        mem_wd    = {1'b1, job};
        wptr_next = wptr + CW'(1);
        if (wptr == wend) begin
          state_next = S_FIN;
        end
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next      = 1'b1;
          rsp_next.success    = res_ok;
          rsp_next.free_pages = res_free;
          state_next          = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      q_vld      <= 1'b0;
      issue_done <= 1'b0;
      have       <= 1'b0;
      rsp_valid  <= 1'b0;
      n_reg      <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      clr_reply  <= clr_reply_next;
      q_vld      <= q_vld_next;
      issue_done <= issue_done_next;
      have       <= have_next;
      rsp_valid  <= rsp_valid_next;
      n_reg      <= n_reg_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    act        <= act_next;
    size       <= size_next;
    job        <= job_next;
    nofit      <= nofit_next;
    ptr        <= ptr_next;
    q_idx      <= q_idx_next;
    run_len    <= run_len_next;
    run_start  <= run_start_next;
    pick_start <= pick_start_next;
    pick_len   <= pick_len_next;
    cnt_free   <= cnt_free_next;
    wptr       <= wptr_next;
    wend       <= wend_next;
    res_ok     <= res_ok_next;
    res_free   <= res_free_next;
    rsp        <= rsp_next;
  end

  // The marked run stays inside the active pages
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (wend < n_reg) && (wptr <= wend))
    else $error("allocation run leaves the active pages");

  // Writing only follows a found hole
  a_write_has_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> have)
    else $error("run written without a chosen hole");

  // Scan pipeline never runs past the end marker
  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    q_vld |-> (q_idx <= n_reg) && (state == S_SCAN))
    else $error("scan index beyond active pages");

  // Free count never exceeds the active count of the item
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (res_free <= n_reg))
    else $error("free page count exceeds active pages");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the page allocator: directed and random items.
`timescale 1ns / 100ps

module tb;

  localparam int          TABLE_PAGES   = 64;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int          MISMATCH_SHOW = 10;
  localparam int          POOL_JOBS     = 6;

  // Field widths from the package
  localparam int ACTION_W   = pgalloc_pkg::ACTION_W;
  localparam int COUNT_W    = pgalloc_pkg::COUNT_W;
  localparam int OWNER_W    = pgalloc_pkg::OWNER_W;
  localparam int POLICY_W   = pgalloc_pkg::POLICY_W;
  localparam int CFG_IDX_W  = pgalloc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pgalloc_pkg::CFG_DATA_W;

  // Codes the package leaves unnamed
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [POLICY_W-1:0] FIT_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  pgalloc_pkg::req_t     req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  pgalloc_pkg::rsp_t     rsp;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the page table and registers
  logic [POLICY_W-1:0] fit_sel;
  logic [COUNT_W-1:0]  window_cfg;
  bit                  page_used [TABLE_PAGES];
  logic [OWNER_W-1:0]  page_job  [TABLE_PAGES];

  // Outcomes awaiting their response, oldest first
  pgalloc_pkg::rsp_t outcome_q [$];

  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;  // no gaps on either side while set
  int unsigned hold_len    = 0;     // request for a long receiver hold-off

  page_allocator_fit_policies i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL page_allocator_fit_policies");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Allocator prediction
  // ---------------------------------------------------------------------

  function automatic int window_pages();
    return (window_cfg > TABLE_PAGES) ? TABLE_PAGES : int'(window_cfg);
  endfunction

  function automatic logic [COUNT_W-1:0] free_in_window();
    int cnt;
    int n;
    n = window_pages();
    cnt = 0;
    for (int i = 0; i < n; i++)
      if (!page_used[i]) cnt++;
    return COUNT_W'(cnt);
  endfunction

  // Find a hole under the current policy and claim it; 1 on success
  function automatic bit place_run(logic [COUNT_W-1:0] size, logic [OWNER_W-1:0] job);
    int n;
    int run_start;
    int run_len;
    int pick_start;
    int pick_len;
    bit have;
    bit lowest;
    bit here;
    bit better;
    n = window_pages();
    lowest = !(fit_sel == pgalloc_pkg::FIT_BEST || fit_sel == pgalloc_pkg::FIT_WORST);
    if (size == 0 || size > n) return 1'b0;
    run_start = 0;
    run_len = 0;
    pick_start = 0;
    pick_len = 0;
    have = 1'b0;
    for (int i = 0; i <= n; i++) begin
      here = (i < n) && !page_used[i];
      if (here) begin
        if (run_len == 0) run_start = i;
        run_len++;
        if (lowest && run_len >= size) begin
          have = 1'b1;
          pick_start = run_start;
          break;
        end
      end else begin
        // a hole just ended; ties keep the earlier hole
        if (!lowest && run_len >= size) begin
          if (!have) better = 1'b1;
          else if (fit_sel == pgalloc_pkg::FIT_BEST) better = run_len < pick_len;
          else better = run_len > pick_len;
          if (better) begin
            have = 1'b1;
            pick_start = run_start;
            pick_len = run_len;
          end
        end
        run_len = 0;
      end
    end
    if (!have) return 1'b0;
    for (int i = pick_start; i < pick_start + size && i < TABLE_PAGES; i++) begin
      page_used[i] = 1'b1;
      page_job[i] = job;
    end
    return 1'b1;
  endfunction

  function automatic pgalloc_pkg::rsp_t predict_outcome(pgalloc_pkg::req_t item);
    pgalloc_pkg::rsp_t o;
    bit ok;
    int n;
    ok = 1'b0;
    n = window_pages();
    case (item.action)
      pgalloc_pkg::ACT_CLEAR: begin
        // whole table, active or not
        for (int i = 0; i < TABLE_PAGES; i++) begin
          page_used[i] = 1'b0;
          page_job[i] = '0;
        end
        ok = 1'b1;
      end
      pgalloc_pkg::ACT_ALLOC: ok = place_run(item.request_size, item.owner_job);
      pgalloc_pkg::ACT_FREE: begin
        for (int i = 0; i < n; i++)
          if (page_used[i] && page_job[i] == item.owner_job) begin
            page_used[i] = 1'b0;
            page_job[i] = '0;
          end
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    o.success = ok;
    o.free_pages = free_in_window();
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------

  task automatic note_mismatch(string what, pgalloc_pkg::rsp_t want, pgalloc_pkg::rsp_t got);
    mismatches++;
    if (mismatches <= MISMATCH_SHOW)
      $display("mismatch at cycle %0d (%s): expected success=%0d free_pages=%0d,",
               cycle_count, what, want.success, want.free_pages,
               " got success=%0d free_pages=%0d", got.success, got.free_pages);
  endtask

  // Receiver hold-off: random gaps, or a long stretch on request
  initial begin : rsp_stall_gen
    int unsigned run;
    int unsigned g;
    run = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        run = hold_len;
        hold_len = 0;
      end
      if (run != 0) begin
        rsp_stall <= 1'b1;
        run--;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else begin
        g = pick_gap();
        rsp_stall <= (g != 0);
        run = (g != 0) ? g - 1 : 0;
      end
    end
  end

  // Compare each accepted response with the oldest outcome
  always @(posedge clk) begin : rsp_check
    pgalloc_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("response with no item pending", '0, rsp);
      end else begin
        want = outcome_q.pop_front();
        if (rsp.success !== want.success && rsp.free_pages !== want.free_pages)
          note_mismatch("success and free_pages", want, rsp);
        else if (rsp.success !== want.success)
          note_mismatch("success", want, rsp);
        else if (rsp.free_pages !== want.free_pages)
          note_mismatch("free_pages", want, rsp);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [COUNT_W-1:0] size,
                           input logic [OWNER_W-1:0] job);
    pgalloc_pkg::req_t item;
    int unsigned gap;
    item.action = act;
    item.request_size = size;
    item.owner_job = job;
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall !== 1'b0);
    outcome_q.push_back(predict_outcome(item));
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every outcome has been matched
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, back to back; only while the block is idle
  task automatic set_config(input logic [POLICY_W-1:0] pol, input logic [COUNT_W-1:0] pages);
    cfg_wr_en <= 1'b1;
    cfg_index <= pgalloc_pkg::REG_FIT_POLICY;
    cfg_data <= CFG_DATA_W'(pol);
    @(posedge clk);
    cfg_index <= pgalloc_pkg::REG_ACTIVE_PAGES;
    cfg_data <= CFG_DATA_W'(pages);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fit_sel = pol;
    window_cfg = pages;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings: empty free, bad sizes, full table, unknown action
  task automatic test_directed_basics();
    send_item(pgalloc_pkg::ACT_FREE, 7'd0, 8'h00);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd0, 8'h5A);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd127, 8'hA5);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd64, 8'hFF);
    send_item(ACT_UNKNOWN, 7'h2A, 8'h55);
    send_item(pgalloc_pkg::ACT_FREE, 7'd1, 8'hFF);
  endtask

  // Window of zero, saturated window, and clear reaching outside the window
  task automatic test_window_edges();
    wait_drained();
    set_config(pgalloc_pkg::FIT_FIRST, 7'd0);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd1, 8'h07);
    send_item(pgalloc_pkg::ACT_FREE, 7'd1, 8'h07);
    wait_drained();
    set_config(pgalloc_pkg::FIT_FIRST, 7'd127);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd64, 8'hF0);
    wait_drained();
    set_config(pgalloc_pkg::FIT_FIRST, 7'd1);
    send_item(pgalloc_pkg::ACT_CLEAR, 7'd0, 8'h00);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd1, 8'h0F);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd1, 8'h0E);
    wait_drained();
    set_config(pgalloc_pkg::FIT_FIRST, 7'd64);
    send_item(pgalloc_pkg::ACT_ALLOC, 7'd63, 8'h33);
  endtask

  // Two equal holes, then holes of different size, under each other policy
  task automatic test_fit_choice();
    logic [POLICY_W-1:0] pols [3];
    pols[0] = pgalloc_pkg::FIT_BEST;
    pols[1] = pgalloc_pkg::FIT_WORST;
    pols[2] = FIT_UNKNOWN;
    foreach (pols[k]) begin
      wait_drained();
      set_config(pols[k], 7'd8);
      send_item(pgalloc_pkg::ACT_CLEAR, 7'd0, 8'h00);
      send_item(pgalloc_pkg::ACT_ALLOC, 7'd3, 8'h01);
      send_item(pgalloc_pkg::ACT_ALLOC, 7'd2, 8'h02);
      send_item(pgalloc_pkg::ACT_FREE, 7'd0, 8'h01);
      send_item(pgalloc_pkg::ACT_ALLOC, 7'd1, 8'h03);
      send_item(pgalloc_pkg::ACT_ALLOC, 7'd2, 8'h04);
      send_item(pgalloc_pkg::ACT_ALLOC, 7'd3, 8'h05);
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_drained();
    set_config(pgalloc_pkg::FIT_FIRST, 7'd16);
    calm = 1'b1;
    hold_len = 300;
    send_item(pgalloc_pkg::ACT_CLEAR, 7'd0, 8'h00);
    for (int i = 0; i < 10; i++)
      send_item(pgalloc_pkg::ACT_ALLOC, 7'd1, 8'h3C);
    calm = 1'b0;
    wait_drained();
  endtask

  // Phases of random settings; mostly allocate and free over a small job pool
  task automatic test_random_mix(input int phases, input int per_phase);
    logic [OWNER_W-1:0]  pool [POOL_JOBS];
    logic [POLICY_W-1:0] pol;
    logic [COUNT_W-1:0]  pages;
    logic [OWNER_W-1:0]  job;
    int unsigned r;
    int sz;
    int n;
    for (int p = 0; p < phases; p++) begin
      wait_drained();
      case (p)
        0: begin pol = pgalloc_pkg::FIT_FIRST; pages = 7'd64;  end
        1: begin pol = pgalloc_pkg::FIT_BEST;  pages = 7'd1;   end
        2: begin pol = pgalloc_pkg::FIT_WORST; pages = 7'd0;   end
        3: begin pol = FIT_UNKNOWN;            pages = 7'd127; end
        default: begin
          pol = POLICY_W'($urandom_range(0, 3));
          r = $urandom_range(0, 9);
          pages = (r == 0) ? COUNT_W'($urandom_range(65, 127))
                           : COUNT_W'($urandom_range(1, 64));
        end
      endcase
      set_config(pol, pages);
      foreach (pool[k]) pool[k] = OWNER_W'($urandom_range(0, 255));
      calm = ($urandom_range(0, 5) == 0);
      n = (pages > TABLE_PAGES) ? TABLE_PAGES : int'(pages);
      for (int i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 99);
        job = ($urandom_range(0, 19) == 0) ? OWNER_W'($urandom_range(0, 255))
                                           : pool[$urandom_range(0, POOL_JOBS - 1)];
        if (r < 58) begin
          // sizes lean small so that holes form; a few are zero or too big
          r = $urandom_range(0, 99);
          if (n == 0 || r < 3) sz = (r < 2) ? 0 : $urandom_range(1, 127);
          else if (r < 6) sz = $urandom_range(n + 1, 127);
          else if (r < 30) sz = $urandom_range(1, n);
          else sz = $urandom_range(1, n / 4 + 1);
          send_item(pgalloc_pkg::ACT_ALLOC, COUNT_W'(sz), job);
        end else if (r < 88) begin
          send_item(pgalloc_pkg::ACT_FREE, COUNT_W'($urandom_range(0, 127)), job);
        end else if (r < 92) begin
          send_item(pgalloc_pkg::ACT_CLEAR, COUNT_W'($urandom_range(0, 127)), job);
        end else if (r < 95) begin
          send_item(ACT_UNKNOWN, COUNT_W'($urandom_range(0, 127)), job);
        end else begin
          send_item(ACTION_W'($urandom_range(0, 3)), COUNT_W'($urandom_range(0, 127)),
                    OWNER_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fit_sel = pgalloc_pkg::FIT_FIRST;
    window_cfg = COUNT_W'(TABLE_PAGES);
    for (int i = 0; i < TABLE_PAGES; i++) begin
      page_used[i] = 1'b0;
      page_job[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_window_edges();
    test_fit_choice();
    test_backpressure();
    test_random_mix(12, 85);

    wait_drained();
    repeat (2 * TABLE_PAGES + 8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS page_allocator_fit_policies");
    else
      $display("FAIL page_allocator_fit_policies");
    $finish;
  end

endmodule
